// ===== sv/page_framebuffer_draw_engine_macros.svh =====
// Assertion macros shared by the frame store draw engine.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFDE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfde check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFDE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfde check failed");

`endif

// ===== sv/pfde_pkg.sv =====
// Shared types, constants and helper functions of the frame store draw engine.
`default_nettype none

package pfde_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int DEPTH   = COLUMNS * PAGES;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int ADDR_W  = $clog2(DEPTH);

	typedef logic [2:0] cmd_code_t;

	localparam cmd_code_t CMD_FILL    = 3'd0;
	localparam cmd_code_t CMD_WRITE   = 3'd1;
	localparam cmd_code_t CMD_READ    = 3'd2;
	localparam cmd_code_t CMD_INVERT  = 3'd3;
	localparam cmd_code_t CMD_BITMAP  = 3'd4;
	localparam cmd_code_t CMD_PAGE    = 3'd5;
	localparam cmd_code_t CMD_COLBYTE = 3'd6;
	localparam cmd_code_t CMD_IGNORE  = 3'd7;

	localparam logic [7:0] PAGE_BASE  = 8'hb0;
	localparam logic [7:0] NIBBLE_MSK = 8'h0f;
	localparam logic [7:0] HIGH_BASE  = 8'h10;
	localparam logic [7:0] ONE_BYTE   = 8'h01;
	localparam logic [3:0] MAX_COUNT  = 4'd8;

	typedef struct packed {
		cmd_code_t  cmd;
		logic [6:0] x_pos;
		logic [5:0] y_pos;
		logic       bit_value;
		logic [7:0] data_byte;
		logic [3:0] pixel_count;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       pixel;
		logic       last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sweep_wr;
		logic rd;
		logic wr;
		logic next_pix;
		logic emit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_code_t req_cmd;
		logic      req_cnt_zero;
		cmd_code_t item_cmd;
		logic      sweep_done;
		logic      pix_last;
		logic      emit_last;
		logic      out_free;
	} stat_t;

	// Remainder of a narrow value by a small constant, by restoring subtraction.
	function automatic logic [7:0] mod_small(input logic [7:0] v, input logic [8:0] m);
		logic [15:0] r;
		logic [15:0] d;
		r = {8'd0, v};
		for (int i = 7; i >= 0; i--) begin
			d = {7'd0, m} << i;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[7:0];
	endfunction

	// Bit mask of a bitmap pixel, leftmost pixel in the most significant bit.
	function automatic logic [7:0] msb_mask(input logic [2:0] k);
		return 8'h80 >> k;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pfde_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/pfde_ctrl.sv =====
// Controller state machine of the frame store draw engine.
`default_nettype none

module pfde_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output      logic            req_stall,
	input  wire pfde_pkg::stat_t stat,
	output      pfde_pkg::ctl_t  ctl
);

	pfde_pkg::state_t state_q;
	pfde_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfde_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_stall = 1'b1;
		case (state_q)
			pfde_pkg::ST_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (stat.sweep_done) begin
					state_d = pfde_pkg::ST_IDLE;
				end
			end
			pfde_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					ctl.load = 1'b1;
					case (stat.req_cmd)
						pfde_pkg::CMD_FILL: state_d = pfde_pkg::ST_SWEEP;
						pfde_pkg::CMD_WRITE, pfde_pkg::CMD_READ, pfde_pkg::CMD_INVERT,
						pfde_pkg::CMD_COLBYTE: state_d = pfde_pkg::ST_READ;
						pfde_pkg::CMD_BITMAP: begin
							state_d = stat.req_cnt_zero ? pfde_pkg::ST_IDLE
								: pfde_pkg::ST_READ;
						end
						pfde_pkg::CMD_PAGE: state_d = pfde_pkg::ST_EMIT;
						default: state_d = pfde_pkg::ST_IDLE;
					endcase
				end
			end
			pfde_pkg::ST_READ: begin
				ctl.rd  = 1'b1;
				state_d = pfde_pkg::ST_MODIFY;
			end
			pfde_pkg::ST_MODIFY: begin
				if (stat.item_cmd inside {pfde_pkg::CMD_READ, pfde_pkg::CMD_COLBYTE}) begin
					state_d = pfde_pkg::ST_EMIT;
				end else begin
					ctl.wr = 1'b1;
					if (stat.item_cmd == pfde_pkg::CMD_BITMAP && !stat.pix_last) begin
						ctl.next_pix = 1'b1;
						state_d      = pfde_pkg::ST_READ;
					end else begin
						state_d = pfde_pkg::ST_IDLE;
					end
				end
			end
			pfde_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = pfde_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = pfde_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/pfde_dp.sv =====
// Datapath of the frame store draw engine: item registers, frame memory, result register.
`default_nettype none

module pfde_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pfde_pkg::req_t  req,
	output      logic            rsp_valid,
	input  wire logic            rsp_stall,
	output      pfde_pkg::rsp_t  rsp,
	input  wire pfde_pkg::ctl_t  ctl,
	output      pfde_pkg::stat_t stat
);

	pfde_pkg::req_t                  item_q;
	logic [pfde_pkg::COL_W-1:0]      col_q;
	logic [pfde_pkg::PAGE_W-1:0]     page_q;
	logic [3:0]                      cnt_q;
	logic [2:0]                      k_q;
	logic [1:0]                      emit_q;
	logic [pfde_pkg::ADDR_W-1:0]     sweep_q;
	logic [7:0]                      fill_q;
	pfde_pkg::rsp_t                  rsp_q;
	logic                            rsp_valid_q;

	logic [pfde_pkg::COL_W:0]        col_sum;
	logic [pfde_pkg::COL_W-1:0]      col_k;
	logic [pfde_pkg::ADDR_W-1:0]     cur_addr;
	logic [7:0]                      rdata;
	logic [7:0]                      wdata;
	logic [2:0]                      sh;
	logic                            new_bit;
	logic [7:0]                      col8;
	pfde_pkg::rsp_t                  res;
	logic                            out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	// Column of the current bitmap pixel; it stays below twice the width.
	always_comb begin
		col_sum = (pfde_pkg::COL_W + 1)'(col_q) + (pfde_pkg::COL_W + 1)'(k_q);
		if (col_sum >= (pfde_pkg::COL_W + 1)'(pfde_pkg::COLUMNS)) begin
			col_sum = col_sum - (pfde_pkg::COL_W + 1)'(pfde_pkg::COLUMNS);
		end
		col_k = col_sum[pfde_pkg::COL_W-1:0];
	end

	assign cur_addr = pfde_pkg::ADDR_W'(page_q) * pfde_pkg::ADDR_W'(pfde_pkg::COLUMNS)
		+ pfde_pkg::ADDR_W'(col_k);

	assign sh = item_q.y_pos[2:0];

	always_comb begin
		case (item_q.cmd)
			pfde_pkg::CMD_WRITE:  new_bit = item_q.bit_value;
			pfde_pkg::CMD_INVERT: new_bit = ~rdata[sh];
			pfde_pkg::CMD_BITMAP: new_bit = |(item_q.data_byte & pfde_pkg::msb_mask(k_q));
			default:              new_bit = rdata[sh];
		endcase
		wdata     = rdata;
		wdata[sh] = new_bit;
	end

	pfde_ram #(
		.WIDTH(8),
		.DEPTH(pfde_pkg::DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ctl.sweep_wr || ctl.wr),
		.waddr (ctl.sweep_wr ? sweep_q : cur_addr),
		.wdata (ctl.sweep_wr ? fill_q : wdata),
		.re    (ctl.rd),
		.raddr (cur_addr),
		.rdata (rdata)
	);

	assign col8 = 8'(col_q);

	always_comb begin
		res = '0;
		case (item_q.cmd)
			pfde_pkg::CMD_PAGE: begin
				case (emit_q)
					2'd0: res.out_byte = pfde_pkg::PAGE_BASE + 8'(page_q);
					2'd1: res.out_byte = col8 & pfde_pkg::NIBBLE_MSK;
					default: begin
						res.out_byte = pfde_pkg::HIGH_BASE | ((col8 >> 4) & pfde_pkg::NIBBLE_MSK);
						res.last     = 1'b1;
					end
				endcase
			end
			pfde_pkg::CMD_COLBYTE: begin
				res.out_byte = rdata;
				res.is_data  = 1'b1;
				res.last     = 1'b1;
			end
			default: begin
				res.pixel = |(rdata & (pfde_pkg::ONE_BYTE << sh));
				res.last  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			emit_q      <= '0;
			sweep_q     <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				k_q     <= '0;
				emit_q  <= '0;
				sweep_q <= '0;
				fill_q  <= req.data_byte;
			end
			if (ctl.sweep_wr) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.next_pix) begin
				k_q <= k_q + 1'b1;
			end
			if (ctl.emit) begin
				emit_q      <= emit_q + 1'b1;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= req;
			col_q  <= pfde_pkg::COL_W'(pfde_pkg::mod_small({1'b0, req.x_pos},
				9'(pfde_pkg::COLUMNS)));
			page_q <= pfde_pkg::PAGE_W'(pfde_pkg::mod_small({5'd0, req.y_pos[5:3]},
				9'(pfde_pkg::PAGES)));
			cnt_q  <= (req.pixel_count > pfde_pkg::MAX_COUNT) ? pfde_pkg::MAX_COUNT
				: req.pixel_count;
		end
		if (ctl.emit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign stat.req_cmd      = req.cmd;
	assign stat.req_cnt_zero = (req.pixel_count == 4'd0);
	assign stat.item_cmd     = item_q.cmd;
	assign stat.sweep_done   = (sweep_q == pfde_pkg::ADDR_W'(pfde_pkg::DEPTH - 1));
	assign stat.pix_last     = (({1'b0, k_q} + 4'd1) == cnt_q);
	assign stat.emit_last    = (item_q.cmd != pfde_pkg::CMD_PAGE) || (emit_q == 2'd2);
	assign stat.out_free     = out_free;

endmodule

`default_nettype wire

// ===== sv/page_framebuffer_draw_engine.sv =====
// Top level of the page-organized monochrome frame store with drawing commands.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  pfde_pkg::req_t (one draw command)
// rsp       out        rsp_valid/rsp_stall  pfde_pkg::rsp_t (command byte, data byte or pixel)
//
// One command is worked at a time; the frame memory has one read and one write port.
// Write and invert pixel read then write the byte; read pixel and column byte read then emit;
// page start emits three bytes, and a bitmap byte does a read then a write per pixel.
// Fill sweeps the whole memory, one byte a cycle.
// After reset a clearing pass over the whole memory runs before the first command.
// A stalled result holds in the output register; the next command is taken meanwhile.
`default_nettype none
`include "page_framebuffer_draw_engine_macros.svh"

module page_framebuffer_draw_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_stall,
	input  wire pfde_pkg::req_t req,
	output      logic           rsp_valid,
	input  wire logic           rsp_stall,
	output      pfde_pkg::rsp_t rsp
);

	pfde_pkg::ctl_t  ctl;
	pfde_pkg::stat_t stat;

	pfde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	pfde_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ctl       (ctl),
		.stat      (stat)
	);

	// No transaction is taken while the memory is being swept.
	`PFDE_ASSERT_SAME(a_sweep_blocks_req, clk, arst_n, ctl.sweep_wr, req_stall)

	// A display data byte is always the only result of its command.
	`PFDE_ASSERT_SAME(a_data_is_last, clk, arst_n, rsp_valid && rsp.is_data, rsp.last)

	// An accepted fill starts a sweep in the next cycle.
	`PFDE_ASSERT_NEXT(a_fill_sweeps, clk, arst_n,
		req_valid && !req_stall && req.cmd == pfde_pkg::CMD_FILL, ctl.sweep_wr)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the page-organized frame store draw engine.
module tb;

	localparam int IDLE_LIMIT   = 8000;
	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	pfde_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	pfde_pkg::rsp_t rsp;

	logic [7:0] frame_img [0:pfde_pkg::DEPTH-1];
	pfde_pkg::req_t draw_cmd_q [$];
	pfde_pkg::rsp_t exp_rsp_q [$];
	int mismatch_cnt = 0;
	int idle_cycles = 0;
	logic req_fire = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	page_framebuffer_draw_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic pfde_pkg::req_t make_cmd(pfde_pkg::cmd_code_t c, logic [6:0] x,
			logic [5:0] y, logic b, logic [7:0] d, logic [3:0] n);
		pfde_pkg::req_t r;
		r.cmd = c;
		r.x_pos = x;
		r.y_pos = y;
		r.bit_value = b;
		r.data_byte = d;
		r.pixel_count = n;
		return r;
	endfunction

	task automatic push_display_byte(logic [7:0] b, logic d, logic p, logic l);
		pfde_pkg::rsp_t e;
		e.out_byte = b;
		e.is_data = d;
		e.pixel = p;
		e.last = l;
		exp_rsp_q.push_back(e);
	endtask

	// Applies one accepted command to the frame image and queues the bytes it emits.
	task automatic apply_draw_cmd(pfde_pkg::req_t r);
		logic [pfde_pkg::ADDR_W-1:0] a;
		logic [6:0] c;
		int n;
		a = {r.y_pos[5:3], r.x_pos};
		case (r.cmd)
			pfde_pkg::CMD_FILL: begin
				foreach (frame_img[i]) frame_img[i] = r.data_byte;
			end
			pfde_pkg::CMD_WRITE: begin
				frame_img[a][r.y_pos[2:0]] = r.bit_value;
			end
			pfde_pkg::CMD_READ: begin
				push_display_byte(8'h00, 1'b0, frame_img[a][r.y_pos[2:0]], 1'b1);
			end
			pfde_pkg::CMD_INVERT: begin
				frame_img[a][r.y_pos[2:0]] = ~frame_img[a][r.y_pos[2:0]];
			end
			pfde_pkg::CMD_BITMAP: begin
				n = (r.pixel_count > pfde_pkg::MAX_COUNT) ? int'(pfde_pkg::MAX_COUNT)
					: int'(r.pixel_count);
				for (int k = 0; k < n; k++) begin
					c = r.x_pos + 7'(k);
					frame_img[{r.y_pos[5:3], c}][r.y_pos[2:0]] = r.data_byte[7-k];
				end
			end
			pfde_pkg::CMD_PAGE: begin
				push_display_byte(pfde_pkg::PAGE_BASE + 8'(r.y_pos[5:3]), 1'b0, 1'b0, 1'b0);
				push_display_byte(8'(r.x_pos) & pfde_pkg::NIBBLE_MSK, 1'b0, 1'b0, 1'b0);
				push_display_byte(pfde_pkg::HIGH_BASE | 8'(r.x_pos >> 4), 1'b0, 1'b0, 1'b1);
			end
			pfde_pkg::CMD_COLBYTE: begin
				push_display_byte(frame_img[a], 1'b1, 1'b0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic note_mismatch(string what, pfde_pkg::rsp_t want, pfde_pkg::rsp_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%s: want byte=%02h data=%0b pix=%0b last=%0b,", what,
				want.out_byte, want.is_data, want.pixel, want.last);
			$display("    got byte=%02h data=%0b pix=%0b last=%0b",
				got.out_byte, got.is_data, got.pixel, got.last);
		end
	endtask

	// Monitor: checks results, tracks accepted commands and watches for a hang.
	always @(posedge clk) begin
		pfde_pkg::rsp_t want;
		if (!arst_n) begin
			foreach (frame_img[i]) frame_img[i] = 8'h00;
			req_fire <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (exp_rsp_q.size() == 0) begin
					want = '0;
					note_mismatch("unexpected result", want, rsp);
				end else begin
					want = exp_rsp_q.pop_front();
					if (rsp.out_byte !== want.out_byte || rsp.is_data !== want.is_data ||
							rsp.pixel !== want.pixel || rsp.last !== want.last) begin
						note_mismatch("result mismatch", want, rsp);
					end
				end
			end
			req_fire <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				apply_draw_cmd(req);
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Driver: sends queued commands in bursts and stalls the result channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (req_fire) begin
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
						burst_left = $urandom_range(1, 24);
					end
				end
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					req_valid <= 1'b0;
				end else if (draw_cmd_q.size() != 0) begin
					req <= draw_cmd_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end

			stall_phase = stall_phase + 1;
			if (stall_phase % 200 == 0) begin
				stall_mode = $urandom_range(0, 2);
			end
			if (stall_mode == 0) begin
				rsp_stall <= 1'b0;
			end else if (stall_mode == 1) begin
				rsp_stall <= ($urandom_range(0, 2) == 0);
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Random commands: mostly draw-then-read-back runs around one spot, some noise and fills.
	task automatic add_random_cmds(int want);
		int added;
		int run_len;
		logic [6:0] ax;
		logic [5:0] ay;
		pfde_pkg::req_t r;
		added = 0;
		while (added < want) begin
			if ($urandom_range(0, 99) < 2) begin
				r = pfde_pkg::req_t'($urandom);
				r.cmd = pfde_pkg::CMD_FILL;
				draw_cmd_q.push_back(r);
				added++;
			end else if ($urandom_range(0, 99) < 15) begin
				r = pfde_pkg::req_t'($urandom);
				if (r.cmd == pfde_pkg::CMD_FILL) r.cmd = pfde_pkg::CMD_IGNORE;
				draw_cmd_q.push_back(r);
				if (r.cmd != pfde_pkg::CMD_IGNORE) added++;
			end else begin
				ax = 7'($urandom);
				ay = 6'($urandom);
				run_len = $urandom_range(2, 6);
				for (int i = 0; i < run_len; i++) begin
					r = pfde_pkg::req_t'($urandom);
					r.x_pos = ax + 7'($urandom_range(0, 9));
					r.y_pos = ($urandom_range(0, 1) == 0) ? ay : {ay[5:3], 3'($urandom)};
					if ($urandom_range(0, 3) != 0) r.pixel_count = 4'($urandom_range(1, 8));
					if (i == run_len - 1) begin
						r.cmd = ($urandom_range(0, 1) == 0) ? pfde_pkg::CMD_READ
							: pfde_pkg::CMD_COLBYTE;
						r.x_pos = ax;
					end else begin
						r.cmd = pfde_pkg::cmd_code_t'($urandom_range(pfde_pkg::CMD_WRITE,
							pfde_pkg::CMD_COLBYTE));
					end
					draw_cmd_q.push_back(r);
					added++;
				end
			end
		end
	endtask

	task automatic wait_until_quiet();
		while (draw_cmd_q.size() != 0 || req_valid || exp_rsp_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		// Corners, fills, pixel edits, bitmap wrap and count limits, refresh bytes.
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_FILL, 7'd0, 6'd0, 1'b0, 8'ha5, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd127, 6'd63, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_READ, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_WRITE, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_READ, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_WRITE, 7'd127, 6'd63, 1'b1, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_INVERT, 7'd127, 6'd63, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_READ, 7'd127, 6'd63, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_BITMAP, 7'd124, 6'd9, 1'b0, 8'hb7, 4'd8));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd124, 6'd9, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd0, 6'd9, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_BITMAP, 7'd10, 6'd17, 1'b1, 8'hff, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd10, 6'd17, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_BITMAP, 7'd20, 6'd31, 1'b0, 8'h5a, 4'd15));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd27, 6'd31, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd28, 6'd31, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_PAGE, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_PAGE, 7'd127, 6'd63, 1'b1, 8'hff, 4'd15));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_PAGE, 7'h5a, 6'd40, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_IGNORE, 7'd127, 6'd63, 1'b1, 8'hff, 4'd15));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd127, 6'd63, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_FILL, 7'd0, 6'd0, 1'b0, 8'h00, 4'd0));
		draw_cmd_q.push_back(make_cmd(pfde_pkg::CMD_COLBYTE, 7'd64, 6'd32, 1'b0, 8'h00, 4'd0));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The sender holds off between phases until every result is back.
		wait_until_quiet();
		add_random_cmds(RANDOM_ITEMS / 2);
		wait_until_quiet();
		add_random_cmds(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		wait_until_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfde_pkg.sv
sv/pfde_ram.sv
sv/pfde_ctrl.sv
sv/pfde_dp.sv
sv/page_framebuffer_draw_engine.sv
bench/tb.sv
